FILE: rtl/fphs_pkg.sv
// ----------------------------------------------------------------------------
// fphs_pkg
// Types and constants shared by the float16 / snorm8 packing unit.
// ----------------------------------------------------------------------------
package fphs_pkg;

  typedef enum logic {
    CMD_HALF2    = 1'b0,
    CMD_SNORM8X4 = 1'b1
  } cmd_t;

  localparam logic [15:0] HALF_INF   = 16'h7C00;
  localparam logic [15:0] HALF_QUIET = 16'h0200;
  localparam logic [7:0]  EXP_MAX    = 8'hFF;
  localparam logic [7:0]  EXP_ONE    = 8'd127;
  localparam logic [7:0]  EXP_TINY   = 8'd118;
  localparam logic [7:0]  BYTE_NAN   = 8'hFF;
  localparam logic [7:0]  BYTE_POS   = 8'hFF;
  localparam logic [7:0]  BYTE_NEG   = 8'h01;
  localparam logic [7:0]  BYTE_BIAS  = 8'd128;

  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        sat;
    logic        tiny;
    logic [2:0]  kk;
    logic [30:0] prod;
  } lane1_t;

  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        sat;
    logic        tiny;
    logic [2:0]  kk;
    logic [31:0] q;
  } lane2_t;

endpackage

FILE: rtl/float_pack_half2_snorm8x4_unit.sv
// ----------------------------------------------------------------------------
// float_pack_half2_snorm8x4_unit
// Packs float32 operands into two float16 halves or four biased snorm8 bytes.
// ----------------------------------------------------------------------------
// A request carries a command and four float32 bit patterns on the in_
// channel and yields one 32-bit word on the out_ channel. Both channels use
// valid and stall; a request moves when valid is high and stall is low.
// The half command converts operands a and b to float16 with truncation,
// flush to signed zero and saturation to infinity. The snorm command scales
// each operand by 127 with float rounding, then rounds half away from zero.
// The unit is a three-stage pipeline: multiply, float rounding, integer
// rounding and packing. One request is taken every cycle unless a word
// waits on a stalled output. When the receiver stalls with a word waiting,
// the whole pipeline holds and in_stall is raised in the same cycle. A
// synchronous reset clears all valid bits.
module float_pack_half2_snorm8x4_unit
  import fphs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  input  logic [31:0] in_operand_c,
  input  logic [31:0] in_operand_d,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_packed_word
);

  function automatic logic [15:0] to_half(input logic [31:0] b);
    logic [8:0] e16;
    logic [15:0] r;
    e16 = {1'b0, b[30:23]} - 9'd112;
    if (b[30:23] == EXP_MAX) begin
      r = {b[31], 15'd0} | HALF_INF | ((b[22:0] != 23'd0) ? HALF_QUIET : 16'd0);
    end else if (b[30:23] >= 8'd143) begin
      r = {b[31], 15'd0} | HALF_INF;
    end else if (b[30:23] <= 8'd112) begin
      r = {b[31], 15'd0};
    end else begin
      r = {b[31], e16[4:0], b[22:13]};
    end
    return r;
  endfunction

  function automatic lane1_t stage1(input logic [31:0] b);
    lane1_t l;
    logic [31:0] m;
    logic [31:0] p;
    logic [7:0]  kk8;
    m = {8'd0, 1'b1, b[22:0]};
    p = (m << 7) - m;
    kk8 = 8'd126 - b[30:23];
    l.sign = b[31];
    l.nan  = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
    l.sat  = (b[30:23] >= EXP_ONE);
    l.tiny = (b[30:23] <= EXP_TINY);
    l.kk   = kk8[2:0];
    l.prod = p[30:0];
    return l;
  endfunction

  function automatic lane2_t stage2(input lane1_t l);
    lane2_t o;
    logic [24:0] r;
    logic up;
    if (l.prod[30]) begin
      up = l.prod[6] && ((l.prod[5:0] != 6'd0) || l.prod[7]);
      r = {1'b0, l.prod[30:7]} + {24'd0, up};
      o.q = {r, 7'd0};
    end else begin
      up = l.prod[5] && ((l.prod[4:0] != 5'd0) || l.prod[6]);
      r = {1'b0, l.prod[29:6]} + {24'd0, up};
      o.q = {1'b0, r, 6'd0};
    end
    o.sign = l.sign;
    o.nan  = l.nan;
    o.sat  = l.sat;
    o.tiny = l.tiny;
    o.kk   = l.kk;
    return o;
  endfunction

  function automatic logic [7:0] stage3(input lane2_t l);
    logic [32:0] half;
    logic [32:0] sum;
    logic [32:0] t;
    logic [7:0]  b;
    half = 33'd1 << (5'd23 + {2'd0, l.kk});
    sum = {1'b0, l.q} + half;
    t = sum >> (5'd24 + {2'd0, l.kk});
    if (l.nan) begin
      b = BYTE_NAN;
    end else if (l.sat) begin
      b = l.sign ? BYTE_NEG : BYTE_POS;
    end else if (l.tiny) begin
      b = BYTE_BIAS;
    end else begin
      b = l.sign ? (BYTE_BIAS - t[7:0]) : (BYTE_BIAS + t[7:0]);
    end
    return b;
  endfunction

  logic        adv;
  logic        v1_r, v2_r, v3_r;
  cmd_t        cmd1_r, cmd2_r;
  logic [31:0] half1_r, half2_r;
  lane1_t      l1_r [4];
  lane2_t      l2_r [4];
  logic [31:0] word_r;
  logic [31:0] ops [4];
  logic [31:0] word_nxt;

  assign adv      = !v3_r || !out_stall;
  assign in_stall = !adv;
  assign ops[0]   = in_operand_a;
  assign ops[1]   = in_operand_b;
  assign ops[2]   = in_operand_c;
  assign ops[3]   = in_operand_d;

  always_comb begin
    unique case (cmd2_r)
      CMD_HALF2:    word_nxt = half2_r;
      CMD_SNORM8X4: word_nxt = {stage3(l2_r[3]), stage3(l2_r[2]),
                                stage3(l2_r[1]), stage3(l2_r[0])};
      default:      word_nxt = half2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1_r  <= cmd_t'(in_cmd);
      half1_r <= {to_half(in_operand_b), to_half(in_operand_a)};
      cmd2_r  <= cmd1_r;
      half2_r <= half1_r;
      word_r  <= word_nxt;
      for (int i = 0; i < 4; i++) begin
        l1_r[i] <= stage1(ops[i]);
        l2_r[i] <= stage2(l1_r[i]);
      end
    end
  end

  assign out_valid       = v3_r;
  assign out_packed_word = word_r;

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !v1_r && !v2_r && !v3_r)
    else $error("pipeline valid bits not cleared by reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v1_r)
    else $error("accepted request did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && out_stall |=> v1_r == $past(v1_r) && v2_r == $past(v2_r))
    else $error("pipeline moved while the output was stalled");

  a_advance_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && v2_r |=> v3_r)
    else $error("second stage request lost on advance");

endmodule

FILE: tb/float_pack_half2_snorm8x4_unit_test.sv
// ----------------------------------------------------------------------------
// float_pack_half2_snorm8x4_unit_test
// Self-checking bench for the float16 / snorm8 packing unit. A directed table
// covers the extremes and special operands, and a random part mixes both
// commands. Random idles and stalls are applied on both channels. Every
// packed word is compared with a bit-exact integer model of the conversion.
// ----------------------------------------------------------------------------
module float_pack_half2_snorm8x4_unit_test;
  import fphs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 1600;
  localparam int CYCLE_LIMIT     = 200000;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] a, b, c, d;
    bit          known;
    logic [31:0] word;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = 1'b0;
  logic [31:0] in_operand_a = '0;
  logic [31:0] in_operand_b = '0;
  logic [31:0] in_operand_c = '0;
  logic [31:0] in_operand_d = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_packed_word;

  logic [31:0] pending_words[$];
  int          mismatches = 0;
  int          words_checked = 0;
  int          cycles = 0;
  bit          calm = 1'b0;
  int          half_count = 0;
  int          snorm_count = 0;

  float_pack_half2_snorm8x4_unit dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] half_of(logic [31:0] f);
    int e16;
    e16 = int'(f[30:23]) - 112;
    if (f[30:23] == EXP_MAX) return {f[31], 15'h7C00} | (f[22:0] != 0 ? HALF_QUIET : 16'h0);
    if (e16 >= 31) return {f[31], 15'h7C00};
    if (e16 <= 0) return {f[31], 15'h0};
    return {f[31], e16[4:0], f[22:13]};
  endfunction

  function automatic logic [7:0] snorm_of(logic [31:0] f);
    longint p, q, r, halfway;
    int ee, nb, s, sh;
    int t;
    if (f[30:23] == EXP_MAX && f[22:0] != 0) return BYTE_NAN;
    if (f[30:23] >= EXP_ONE) begin
      t = 127;
    end else begin
      ee = (f[30:23] == 0) ? 1 : int'(f[30:23]);
      p = (f[30:23] == 0) ? longint'(f[22:0]) : longint'({1'b1, f[22:0]});
      p = p * 127;
      nb = 0;
      while ((p >> nb) != 0) nb++;
      s = (nb > 24) ? nb - 24 : 0;
      q = p >> s;
      if (s > 0) begin
        r = p & ((longint'(1) << s) - 1);
        halfway = longint'(1) << (s - 1);
        if (r > halfway || (r == halfway && q[0])) q++;
      end
      sh = 150 - ee - s;
      if (sh >= 62) begin
        t = 0;
      end else begin
        t = int'(q >> sh) + int'((q >> (sh - 1)) & 1);
      end
      if (t > 127) t = 127;
    end
    if (f[31] && t != 0) t = -t;
    return 8'(t + 128);
  endfunction

  function automatic logic [31:0] packed_word_of(cmd_t cmd, logic [31:0] a, logic [31:0] b,
                                                 logic [31:0] c, logic [31:0] d);
    if (cmd == CMD_HALF2) return {half_of(b), half_of(a)};
    return {snorm_of(d), snorm_of(c), snorm_of(b), snorm_of(a)};
  endfunction

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {1'($urandom()), 8'($urandom_range(100, 130)), 23'($urandom())};
      2: return {1'($urandom()), 8'($urandom_range(110, 127)), 23'($urandom())};
      3: return {1'($urandom()), 8'($urandom_range(111, 144)), 23'($urandom())};
      4: return {1'($urandom()), 8'($urandom_range(0, 1) ? 8'hFF : 8'h00),
                 23'($urandom_range(0, 1) ? $urandom() : 0)};
      default: return {1'($urandom()), 8'($urandom_range(120, 126)),
                       23'($urandom_range(0, 3)) << 21};
    endcase
  endfunction

  task automatic send_request(cmd_t cmd, logic [31:0] a, logic [31:0] b,
                              logic [31:0] c, logic [31:0] d);
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_operand_a <= a;
    in_operand_b <= b;
    in_operand_c <= c;
    in_operand_d <= d;
    do @(posedge clk); while (in_stall);
    pending_words.push_back(packed_word_of(cmd, a, b, c, d));
    if (cmd == CMD_HALF2) half_count++;
    else snorm_count++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected word %h", out_packed_word);
      end else begin
        if (out_packed_word !== pending_words[0]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected %h, actual %h", pending_words[0], out_packed_word);
          end
        end
        void'(pending_words.pop_front());
        words_checked++;
      end
    end
    out_stall <= (!calm && $urandom_range(0, 99) < 18);
  end

  initial begin
    vector_t table_rows[$];
    vector_t v;
    cmd_t    cmd;
    table_rows = '{
      '{CMD_HALF2, 32'h3F800000, 32'h40000000, 32'h0, 32'h0, 1, 32'h40003C00},
      '{CMD_HALF2, 32'h7F800000, 32'hFFC00001, 32'h0, 32'h0, 1, 32'hFE007C00},
      '{CMD_HALF2, 32'h47800000, 32'hC7800000, 32'h0, 32'h0, 1, 32'hFC007C00},
      '{CMD_HALF2, 32'h00000000, 32'h80000001, 32'h0, 32'h0, 1, 32'h80000000},
      '{CMD_HALF2, 32'h387FFFFF, 32'h38800000, 32'h0, 32'h0, 1, 32'h04000000},
      '{CMD_HALF2, 32'hFF800000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'h7E00FC00},
      '{CMD_HALF2, 32'h477FE000, 32'hB8800000, 32'hFFFFFFFF, 32'h0, 0, 32'h0},
      '{CMD_HALF2, 32'hFFFFFFFF, 32'h3FFFFFFF, 32'h0, 32'h0, 0, 32'h0},
      '{CMD_SNORM8X4, 32'h3F800000, 32'hBF800000, 32'h0, 32'h80000000, 1, 32'h808001FF},
      '{CMD_SNORM8X4, 32'h7FC00000, 32'h7F800000, 32'hFF800000, 32'h40000000, 1, 32'hFF01FFFF},
      '{CMD_SNORM8X4, 32'h3F000000, 32'hBF000000, 32'h0, 32'h0, 1, 32'h808040C0},
      '{CMD_SNORM8X4, 32'hFFFFFFFF, 32'h00000001, 32'h80000001, 32'h7F7FFFFF, 1, 32'hFF8080FF},
      '{CMD_SNORM8X4, 32'h3F7FFFFF, 32'hBF7FFFFF, 32'h3C010204, 32'hBC810204, 0, 32'h0},
      '{CMD_SNORM8X4, 32'h3E7FFFFF, 32'h3B810204, 32'hBB810204, 32'h3F7EFEFF, 0, 32'h0}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) begin
      v = table_rows[i];
      if (v.known && packed_word_of(v.cmd, v.a, v.b, v.c, v.d) !== v.word) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Table row %0d: predicted %h, listed %h", i,
                   packed_word_of(v.cmd, v.a, v.b, v.c, v.d), v.word);
        end
      end
      send_request(v.cmd, v.a, v.b, v.c, v.d);
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      calm = (n >= 600 && n < 800);
      if (n == 1000) begin
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
      end
      cmd = $urandom_range(0, 1) ? CMD_SNORM8X4 : CMD_HALF2;
      send_request(cmd, random_operand(), random_operand(), random_operand(),
                   random_operand());
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d packed words: %0d half pairs and %0d snorm quads.",
             words_checked, half_count, snorm_count);
    $display("Random idles and stalls ran on both channels, with one drain mid-run.");
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
